// ===== hdl/kbsc_pkg.sv =====
// Shared types, constants and a helper function for the keyed byte stream cipher.
// No dependencies.
package kbsc_pkg;

  localparam logic [15:0] SEED_MUL_A = 16'h0de6d;
  localparam logic [15:0] SEED_MUL_B = 16'h0278d;
  localparam logic [31:0] FOLD_MUL   = 32'd17;
  localparam logic [2:0]  LAST_PAIR  = 3'd6;   // key pairs 0..6

  // register index, taken from paddr[3]
  localparam logic REG_KEY  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } kbsc_item_t;

  typedef struct packed {
    logic [15:0] stream;
    logic [31:0] seed;
  } kbsc_fold_t;

  // little-endian key pair; byte above byte 7 reads as zero
  function automatic logic [15:0] key_pair(input logic [63:0] key, input logic [2:0] idx);
    logic [7:0] lo_b;
    logic [7:0] hi_b;
    lo_b = key[{idx, 3'b000} +: 8];
    hi_b = (idx == 3'd7) ? 8'h00 : key[{idx + 3'd1, 3'b000} +: 8];
    return {hi_b, lo_b};
  endfunction

endpackage

// ===== hdl/kbsc_front.sv =====
// Front end: configuration registers, key fold unit and request acceptance.
// Depends on kbsc_pkg.
module kbsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  output logic                push,
  output kbsc_pkg::kbsc_item_t item,
  input  logic                queue_full,
  output logic [63:0]         key,
  output logic                mode,
  output kbsc_pkg::kbsc_fold_t fold
);

  logic        busy;
  logic [2:0]  round;
  logic [31:0] fold_acc;
  logic [31:0] fold_acc_next;
  logic [31:0] fold_done;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == kbsc_pkg::REG_MODE) ? {63'b0, mode} : key;

  // one fold round: swap halves, times 17, add key pair
  assign fold_acc_next = 32'({fold_acc[15:0], fold_acc[31:16]} * kbsc_pkg::FOLD_MUL)
                         + {16'b0, kbsc_pkg::key_pair(key, round)};

  assign fold_done   = fold_acc | 32'd1;
  assign fold.stream = fold_done[15:0];
  assign fold.seed   = {fold_done[15:0], fold_done[31:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      key      <= '0;
      mode     <= 1'b0;
      busy     <= 1'b1;
      round    <= '0;
      fold_acc <= '0;
    end else begin
      if (cfg_wr && paddr[3] == kbsc_pkg::REG_MODE) begin
        mode <= pwdata[0];
      end
      if (cfg_wr && paddr[3] == kbsc_pkg::REG_KEY) begin
        key      <= pwdata;
        busy     <= 1'b1;
        round    <= '0;
        fold_acc <= '0;
      end else if (busy) begin
        fold_acc <= fold_acc_next;
        round    <= round + 3'd1;
        if (round == kbsc_pkg::LAST_PAIR) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign in_ready     = ~busy & ~queue_full;
  assign push         = in_valid & in_ready;
  assign item.data    = data_byte;
  assign item.restart = first_byte;

endmodule

// ===== hdl/kbsc_queue.sv =====
// Two-entry request queue between front and back end.
// Depends on kbsc_pkg.
module kbsc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kbsc_pkg::kbsc_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output kbsc_pkg::kbsc_item_t head
);

  kbsc_pkg::kbsc_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/kbsc_back.sv =====
// Back end: byte transform, seed generator and output register.
// Depends on kbsc_pkg.
module kbsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  kbsc_pkg::kbsc_item_t head,
  output logic                pop,
  input  logic [63:0]         key,
  input  logic                mode,
  input  kbsc_pkg::kbsc_fold_t fold,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte
);

  logic [31:0] seed;
  logic [15:0] stream;
  logic [2:0]  pos;

  logic [31:0] cur_seed;
  logic [15:0] cur_stream;
  logic [2:0]  cur_pos;
  logic [2:0]  sh;
  logic [7:0]  off;
  logic [7:0]  diff;
  logic [15:0] rot_r;
  logic [15:0] rot_l;
  logic [7:0]  result;
  logic [31:0] p1;
  logic [15:0] p2;
  logic [15:0] p3;
  logic [15:0] hi;
  logic [31:0] seed_next;
  logic [15:0] stream_next;
  logic [2:0]  pos_next;

  assign pop = not_empty & (~out_valid | out_ready);

  assign cur_seed   = head.restart ? fold.seed   : seed;
  assign cur_stream = head.restart ? fold.stream : stream;
  assign cur_pos    = head.restart ? 3'd0        : pos;

  assign sh    = cur_stream[2:0];
  assign off   = cur_stream[7:0];
  assign diff  = head.data - off;
  assign rot_r = {head.data, head.data} >> sh;
  assign rot_l = {diff, diff} << sh;
  assign result = mode ? rot_l[15:8] : (rot_r[7:0] + off);

  assign p1 = 32'(kbsc_pkg::SEED_MUL_A) * 32'(cur_seed[15:0]);
  assign p2 = 16'(kbsc_pkg::SEED_MUL_B * cur_seed[15:0]) + p1[31:16];
  assign p3 = 16'(kbsc_pkg::SEED_MUL_A * cur_seed[31:16]);
  assign hi = p3 + p2;

  assign seed_next   = {hi, p1[15:0]};
  assign stream_next = (hi | 16'd1) + kbsc_pkg::key_pair(key, cur_pos);
  assign pos_next    = (cur_pos >= kbsc_pkg::LAST_PAIR) ? 3'd0 : cur_pos + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      stream    <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        seed      <= seed_next;
        stream    <= stream_next;
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= result;
    end
  end

endmodule

// ===== hdl/keyed_byte_stream_cipher_core.sv =====
// Keyed byte stream cipher, top level.
// Depends on kbsc_pkg, kbsc_front, kbsc_queue, kbsc_back.
//
// Takes one byte per cycle and gives one byte per cycle while neither side
// stalls and no key fold runs. A request passes through the queue and the
// output register before its result shows on out_valid. The restart seed is
// derived from the key by a fold unit running one round a cycle: after reset
// and after each key write in_ready stays low until the fold is done. The seed
// generator updates once for each byte popped, which sets the rate. A two-entry
// queue and the output register let both sides stall independently.
module keyed_byte_stream_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte
);

  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 not_empty;
  kbsc_pkg::kbsc_item_t push_item;
  kbsc_pkg::kbsc_item_t head;
  kbsc_pkg::kbsc_fold_t fold;
  logic [63:0]          key;
  logic                 mode;

  kbsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .push       (push),
    .item       (push_item),
    .queue_full (queue_full),
    .key        (key),
    .mode       (mode),
    .fold       (fold)
  );

  kbsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  kbsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .key       (key),
    .mode      (mode),
    .fold      (fold),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
  );

endmodule

// ===== hdl/kbsc_checker.sv =====
// Port-level checks for the keyed byte stream cipher, bound to the top level.
// Depends on keyed_byte_stream_cipher_core.
module kbsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte
);

  // fold unit restarts after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!in_ready && !out_valid))
    else $error("requests taken or result shown right after reset");

  // key write reruns the fold, so requests are held off
  a_key_fold: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[3]) |=> !in_ready)
    else $error("request taken while key fold in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
    else $error("stalled result dropped or changed");

endmodule

bind keyed_byte_stream_cipher_core kbsc_checker u_kbsc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for keyed_byte_stream_cipher_core: directed and random requests,
// each result checked against an in-bench prediction of the cipher state.
// Depends on hdl/keyed_byte_stream_cipher_core.sv and the modules it instantiates.
module testbench;

  localparam logic [3:0]  KEY_ADDR  = 4'h0;
  localparam logic [3:0]  MODE_ADDR = 4'h8;
  localparam logic [31:0] LCG_A     = 32'h0000de6d;
  localparam logic [31:0] LCG_B     = 32'h0000278d;
  localparam logic [31:0] FOLD_K    = 32'd17;
  localparam int          FOLD_ROUNDS = 7;
  localparam logic [2:0]  PAIR_LAST = 3'd6;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;

  // predicted cipher state
  logic [63:0] pk_key = '0;
  logic        pk_decrypt = 1'b0;
  logic [31:0] gen_seed = '0;
  logic [15:0] ks_word = '0;
  logic [2:0]  pair_index = '0;

  logic [7:0]  expected_bytes[$];
  logic        steady = 1'b0;
  int          mismatch_count = 0;
  int          byte_count = 0;
  int          message_count = 0;
  int          key_writes = 0;
  int          decrypt_bytes = 0;

  keyed_byte_stream_cipher_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .first_byte(first_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("keyed_byte_stream_cipher_core test failed");
    $finish;
  end

  function automatic logic [15:0] pair_of_key(input logic [2:0] idx);
    logic [7:0] lo_b;
    logic [7:0] hi_b;
    lo_b = 8'(pk_key >> (8 * idx));
    hi_b = (idx == 3'd7) ? 8'h00 : 8'(pk_key >> (8 * (idx + 1)));
    return {hi_b, lo_b};
  endfunction

  function automatic void fold_key();
    logic [31:0] s;
    s = '0;
    for (int r = 0; r < FOLD_ROUNDS; r++)
      s = {s[15:0], s[31:16]} * FOLD_K + {16'h0000, pair_of_key(3'(r))};
    s[0] = 1'b1;
    ks_word = s[15:0];
    gen_seed = {s[15:0], s[31:16]};
    pair_index = '0;
  endfunction

  function automatic void step_generator();
    logic [31:0] lo;
    logic [31:0] hi_in;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [15:0] hi;
    lo = {16'h0000, gen_seed[15:0]};
    hi_in = {16'h0000, gen_seed[31:16]};
    p1 = LCG_A * lo;
    p2 = LCG_B * lo + (p1 >> 16);
    p3 = LCG_A * hi_in;
    hi = 16'(p3 + p2);
    gen_seed = {hi, p1[15:0]};
    ks_word = (hi | 16'h0001) + pair_of_key(pair_index);
    pair_index = (pair_index >= PAIR_LAST) ? 3'd0 : pair_index + 3'd1;
  endfunction

  function automatic logic [7:0] cipher_byte(input logic [7:0] c, input logic restart);
    logic [2:0]  sh;
    logic [7:0]  off;
    logic [7:0]  d;
    logic [15:0] twin;
    logic [7:0]  res;
    if (restart) fold_key();
    sh = ks_word[2:0];
    off = ks_word[7:0];
    if (!pk_decrypt) begin
      twin = {c, c} >> sh;
      res = twin[7:0] + off;
    end else begin
      d = c - off;
      twin = {d, d} << sh;
      res = twin[15:8];
    end
    step_generator();
    return res;
  endfunction

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: out_byte %02h with nothing pending", out_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: out_byte expected %02h got %02h", want, out_byte);
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic restart);
    logic [7:0] predicted;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    data_byte <= b;
    first_byte <= restart;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = cipher_byte(b, restart);
    expected_bytes.push_back(predicted);
    byte_count++;
    if (restart) message_count++;
    if (pk_decrypt) decrypt_bytes++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == KEY_ADDR) begin
      pk_key = value;
      key_writes++;
    end else begin
      pk_decrypt = value[0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] key, input logic decrypt);
    wait_idle();
    write_reg(KEY_ADDR, key);
    write_reg(MODE_ADDR, {63'd0, decrypt});
  endtask

  // no restart from reset: the first byte sees offset and rotate both zero
  task automatic test_no_restart();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b0);
  endtask

  task automatic test_encrypt_extremes();
    set_config('1, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    set_config('0, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_decrypt();
    set_config({$urandom, $urandom}, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // new key mixes into the running message, full effect at next restart
  task automatic test_key_change_mid_message();
    set_config(64'h0123_4567_89AB_CDEF, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    set_config(64'hFEDC_BA98_7654_3210, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
  endtask

  task automatic test_random_traffic(input int total);
    int          sent;
    int          phase;
    int          len;
    logic        restart;
    logic [63:0] key;
    sent = 0;
    phase = 0;
    while (sent < total) begin
      case ($urandom_range(3))
        0: key = '0;
        1: key = '1;
        default: key = {$urandom, $urandom};
      endcase
      set_config(key, 1'($urandom_range(1)));
      steady = (phase == 3);
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          restart = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
          send_byte(8'($urandom_range(255)), restart);
        end
        sent += len;
      end
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_no_restart();
    test_encrypt_extremes();
    test_decrypt();
    test_key_change_mid_message();
    test_random_traffic(950);
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d requests in %0d restarted messages, %0d decrypted, %0d key writes",
             byte_count, message_count, decrypt_bytes, key_writes);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("keyed_byte_stream_cipher_core test passed");
    end else begin
      $display("keyed_byte_stream_cipher_core test failed");
    end
    $finish;
  end

endmodule
